// ===== hw/rtl/sac_pkg.sv =====
// shared types, sizes and codes for the stack allocator
`default_nettype none

package sac_pkg;

    localparam int POOL_BYTES   = 65536;
    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 1;

    localparam int OFS_W = $clog2(POOL_BYTES + 1);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int PAD_W = 8;

    typedef logic [PAD_W-1:0] pad_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_RESET = 2'd2
    } cmd_t;

    typedef enum logic {
        REG_BASE_ADDR = 1'b0,
        REG_POOL_SIZE = 1'b1
    } reg_idx_t;

    // control from the allocator to the padding stack
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
        pad_t data;
    } stk_ctl_t;

    // status from the padding stack back to the allocator
    typedef struct packed {
        logic full;
        logic empty;
        pad_t top;
        cnt_t count;
    } stk_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sac_cell.sv =====
// one cell of the padding stack chain: takes from the upper or lower neighbor
`default_nettype none

module sac_cell (
    input  wire logic            aclk,
    input  wire sac_pkg::stk_ctl_t ctl,
    input  wire sac_pkg::pad_t   prev_d,
    input  wire sac_pkg::pad_t   next_d,
    output sac_pkg::pad_t        q
);
    import sac_pkg::*;

    pad_t q_reg;
    pad_t q_next;

    always_comb begin
        q_next = q_reg;
        if (ctl.push) begin
            q_next = prev_d;
        end else if (ctl.pop) begin
            q_next = next_d;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sac_pad_stack.sv =====
// padding stack as a shifting chain of cells, top of stack in cell zero
`default_nettype none

module sac_pad_stack (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sac_pkg::stk_ctl_t ctl,
    output sac_pkg::stk_sts_t      sts
);
    import sac_pkg::*;

    pad_t cell_q [MAX_BLOCKS];
    cnt_t count_reg;
    cnt_t count_next;

    genvar i;
    generate
        for (i = 0; i < MAX_BLOCKS; i++) begin : g_cell
            pad_t prev_d;
            pad_t next_d;
            if (i == 0) begin : g_first
                assign prev_d = ctl.data;
            end else begin : g_mid
                assign prev_d = cell_q[i-1];
            end
            if (i == MAX_BLOCKS - 1) begin : g_last
                assign next_d = '0;
            end else begin : g_inner
                assign next_d = cell_q[i+1];
            end
            sac_cell u_cell (
                .aclk   (aclk),
                .ctl    (ctl),
                .prev_d (prev_d),
                .next_d (next_d),
                .q      (cell_q[i])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (ctl.clear) begin
            count_next = '0;
        end else if (ctl.push) begin
            count_next = count_reg + cnt_t'(1);
        end else if (ctl.pop) begin
            count_next = count_reg - cnt_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign sts.full  = (count_reg >= cnt_t'(MAX_BLOCKS));
    assign sts.empty = (count_reg == '0);
    assign sts.top   = cell_q[0];
    assign sts.count = count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cnt_t'(MAX_BLOCKS))
        else $error("padding stack count above depth");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.push |-> !sts.full)
        else $error("push into full padding stack");
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.pop && !ctl.push && !ctl.clear) |=> count_reg == $past(count_reg) - cnt_t'(1))
        else $error("pop did not lower the count");

endmodule

`default_nettype wire

// ===== hw/rtl/stack_allocator_core.sv =====
// stack allocator top level: request decode, offset and peak tracking, apb registers
//
//  channel | ports        | fields
//  --------+--------------+---------------------------------------------------
//  in      | s_t*         | tuser: cmd; tdata: req_size, alignment, block_addr
//  out     | m_t*         | tuser: fail; tdata: result_addr, used, peak
//  config  | apb          | 0x0 base_addr, 0x4 pool_size
//
// one word per cycle while the output register is empty or drained: each request resolves
// in the cycle it is accepted and its result lands in the output register the next cycle.
// the padding stack is a chain of cells that shifts one place per push or pop.
// s_tready is high whenever the output register is empty or being drained.
// synchronous active-low reset clears offset, peak, stack count, valid and base address.
`default_nettype none

module stack_allocator_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // req_size[16:0], alignment[24:17], block_addr[56:25]
    input  wire logic [1:0]  s_tuser,  // cmd[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,  // result_addr[31:0], used_bytes[48:32], peak_bytes[65:49]
    output logic             m_tuser,  // fail[0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sac_pkg::*;

    logic [31:0]      base_addr_reg;
    logic [OFS_W-1:0] pool_size_reg;
    logic [OFS_W-1:0] top_reg,  top_next;
    logic [OFS_W-1:0] peak_reg, peak_next;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [31:0]      res_addr_reg, res_addr_next;
    logic             fail_reg,     fail_next;

    logic             in_fire;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    cmd_t             cmd;
    logic [16:0]      req_size;
    logic [7:0]       alignment;
    logic [31:0]      block_addr;

    logic [7:0]       align_n;
    logic [7:0]       align_mask;
    logic [31:0]      cur_addr;
    logic [7:0]       cur_hdr;
    pad_t             pad;
    logic [OFS_W+1:0] alloc_end;
    logic [OFS_W-1:0] usable;
    logic [31:0]      restored;

    stk_ctl_t         stk_ctl;
    stk_sts_t         stk_sts;

    assign cmd        = cmd_t'(s_tuser);
    assign req_size   = s_tdata[16:0];
    assign alignment  = s_tdata[24:17];
    assign block_addr = s_tdata[56:25];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // lowest set bit of the alignment, zero means byte aligned
    assign align_n    = (alignment == '0) ? 8'd1 : (alignment & (8'd0 - alignment));
    assign align_mask = align_n - 8'd1;

    assign cur_addr  = base_addr_reg + 32'(top_reg);
    assign cur_hdr   = cur_addr[7:0] + 8'(HEADER_BYTES);
    assign pad       = ((8'd0 - cur_hdr) & align_mask) + 8'(HEADER_BYTES);
    assign alloc_end = (OFS_W+2)'(top_reg) + (OFS_W+2)'(pad) + (OFS_W+2)'(req_size);
    assign usable    = (pool_size_reg < OFS_W'(POOL_BYTES)) ? pool_size_reg
                                                            : OFS_W'(POOL_BYTES);
    assign restored  = block_addr - 32'(stk_sts.top) - base_addr_reg;

    always_comb begin
        top_next      = top_reg;
        peak_next     = peak_reg;
        res_addr_next = res_addr_reg;
        fail_next     = fail_reg;
        stk_ctl       = '{push: 1'b0, pop: 1'b0, clear: 1'b0, data: pad};
        if (in_fire) begin
            res_addr_next = '0;
            fail_next     = 1'b0;
            case (cmd)
                CMD_ALLOC: begin
                    if (stk_sts.full || alloc_end > (OFS_W+2)'(usable)) begin
                        fail_next = 1'b1;
                    end else begin
                        stk_ctl.push  = 1'b1;
                        top_next      = alloc_end[OFS_W-1:0];
                        res_addr_next = cur_addr + 32'(pad);
                        if (alloc_end[OFS_W-1:0] > peak_reg) begin
                            peak_next = alloc_end[OFS_W-1:0];
                        end
                    end
                end
                CMD_FREE: begin
                    // free above the top is refused without a pop
                    if (stk_sts.empty || restored > 32'(top_reg)) begin
                        fail_next = 1'b1;
                    end else begin
                        stk_ctl.pop = 1'b1;
                        top_next    = restored[OFS_W-1:0];
                    end
                end
                CMD_RESET: begin
                    stk_ctl.clear = 1'b1;
                    top_next      = '0;
                    peak_next     = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid_next = in_fire || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg      <= '0;
            peak_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            top_reg      <= top_next;
            peak_reg     <= peak_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_addr_reg <= res_addr_next;
        fail_reg     <= fail_next;
    end

    sac_pad_stack u_pad_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (stk_ctl),
        .sts     (stk_sts)
    );

    // used and peak are the live state, which the next word cannot change until taken
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = fail_reg;
    assign m_tdata  = {6'd0, peak_reg, top_reg, res_addr_reg};

    // apb registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_addr_reg <= '0;
            pool_size_reg <= OFS_W'(POOL_BYTES);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_BASE_ADDR: base_addr_reg <= pwdata;
                REG_POOL_SIZE: pool_size_reg <= pwdata[OFS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_BASE_ADDR: prdata = base_addr_reg;
            REG_POOL_SIZE: prdata = 32'(pool_size_reg);
            default:       prdata = '0;
        endcase
    end

    a_top_le_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg <= peak_reg)
        else $error("offset above peak");
    a_fail_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && fail_reg) |-> res_addr_reg == '0)
        else $error("failed word carries an address");
    a_push_moves_top: assert property (@(posedge aclk) disable iff (!aresetn)
        stk_ctl.push |=> top_reg > $past(top_reg))
        else $error("allocate did not advance the offset");
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> $stable(top_reg) && $stable(peak_reg))
        else $error("state moved under a stalled result");

endmodule

`default_nettype wire
